// ----- sv/macp_pkg.sv -----
// ----------------------------------------------------------------------------
// macp_pkg
// Shared constants and types for the hardware address text parser.
// ----------------------------------------------------------------------------
package macp_pkg;

  // default number of address bytes
  localparam int MACP_ADDRESS_BYTES = 6;

  // width of the address field on the result port
  localparam int MACP_ADDR_W = 48;

  // character codes
  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_DASH    = 8'h2D;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_DOT     = 8'h2E;
  localparam logic [7:0] CHAR_DIGIT0  = 8'h30;
  localparam logic [7:0] CHAR_DIGIT9  = 8'h39;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_F = 8'h66;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;

  // character class from the decoder
  typedef struct packed {
    logic       is_term;
    logic       is_sep;
    logic       is_hex;
    logic [3:0] nibble;
  } char_class_t;

  // end-of-text summary from the parser
  typedef struct packed {
    logic                   ok;
    logic [MACP_ADDR_W-1:0] addr;
  } parse_result_t;

endpackage

// ----- sv/macp_classify.sv -----
// ----------------------------------------------------------------------------
// macp_classify
// Decodes one text character into terminator, separator, hex digit or none of these.
// ----------------------------------------------------------------------------
module macp_classify
  import macp_pkg::*;
(
  input  logic [7:0]  character,
  output char_class_t cls
);

  // character decode
  always_comb begin
    cls = '0;
    case (character) inside
      CHAR_NUL: begin
        cls.is_term = 1'b1;
      end
      CHAR_COLON, CHAR_DASH, CHAR_SPACE, CHAR_DOT: begin
        cls.is_sep = 1'b1;
      end
      [CHAR_DIGIT0:CHAR_DIGIT9]: begin
        cls.is_hex = 1'b1;
        cls.nibble = 4'(character - CHAR_DIGIT0);
      end
      [CHAR_LOWER_A:CHAR_LOWER_F]: begin
        cls.is_hex = 1'b1;
        cls.nibble = 4'(character - CHAR_LOWER_A + 8'd10);
      end
      [CHAR_UPPER_A:CHAR_UPPER_F]: begin
        cls.is_hex = 1'b1;
        cls.nibble = 4'(character - CHAR_UPPER_A + 8'd10);
      end
      default: begin
        cls = '0;
      end
    endcase
  end

endmodule

// ----- sv/macp_parse.sv -----
// ----------------------------------------------------------------------------
// macp_parse
// Holds the parse state, pairs digits into bytes and checks the address.
// ----------------------------------------------------------------------------
module macp_parse
  import macp_pkg::*;
#(
  parameter int ADDRESS_BYTES = MACP_ADDRESS_BYTES
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  char_class_t   cls,
  output parse_result_t result
);

  localparam int VW = 8 * ADDRESS_BYTES;
  localparam int CW = $clog2(ADDRESS_BYTES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(ADDRESS_BYTES);

  logic [VW-1:0] address_shift;
  logic [CW-1:0] byte_count;
  logic [3:0]    pending_digit;
  logic          digit_pending;
  logic          error_seen;
  logic [63:0]   shift_ext;

  // end-of-text check on the current state
  assign shift_ext   = 64'(address_shift);
  assign result.ok   = !error_seen && !digit_pending && (byte_count == FULL_COUNT) &&
                       (|address_shift) && !(&address_shift);
  assign result.addr = shift_ext[MACP_ADDR_W-1:0];

  // parse state update
  always_ff @(posedge clk) begin
    if (rst || (step && cls.is_term)) begin
      address_shift <= '0;
      byte_count    <= '0;
      pending_digit <= '0;
      digit_pending <= 1'b0;
      error_seen    <= 1'b0;
    end else if (step && !error_seen) begin
      if (cls.is_sep) begin
        if (digit_pending) begin
          error_seen <= 1'b1;
        end
      end else if (!cls.is_hex) begin
        error_seen <= 1'b1;
      end else if (!digit_pending) begin
        pending_digit <= cls.nibble;
        digit_pending <= 1'b1;
      end else if (byte_count >= FULL_COUNT) begin
        error_seen <= 1'b1;
      end else begin
        address_shift <= {address_shift[VW-9:0], pending_digit, cls.nibble};
        byte_count    <= byte_count + 1'b1;
        pending_digit <= '0;
        digit_pending <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/mac_address_text_parser_top.sv -----
// A terminator character is held in the input register, and its result is then loaded into the result register.
// Throughput: one character per cycle while char_stall is low.
// A terminator waits in the input register only while an older result is stalled.
// Reset (rst, synchronous) clears the parse state, s1_valid and result_valid.
// ----------------------------------------------------------------------------
// mac_address_text_parser_top
// Parses hardware address text, one character per transaction, into bytes.
// ----------------------------------------------------------------------------
module mac_address_text_parser_top
  import macp_pkg::*;
#(
  parameter int ADDRESS_BYTES = MACP_ADDRESS_BYTES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   char_valid,
  output logic                   char_stall,
  input  logic [7:0]             character,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic                   address_valid,
  output logic [MACP_ADDR_W-1:0] address
);

  logic          s1_valid;
  logic [7:0]    s1_char;
  logic          s1_adv;
  logic          char_accept;
  logic          result_load;
  char_class_t   cls;
  parse_result_t parse_res;

  // decode the registered character
  macp_classify u_classify (
    .character (s1_char),
    .cls       (cls)
  );

  // parse state
  macp_parse #(
    .ADDRESS_BYTES (ADDRESS_BYTES)
  ) u_parse (
    .clk    (clk),
    .rst    (rst),
    .step   (s1_adv),
    .cls    (cls),
    .result (parse_res)
  );

  // only a terminator needs room in the result register
  assign s1_adv      = s1_valid && (!cls.is_term || !result_valid || !result_stall);
  assign char_stall  = s1_valid && !s1_adv;
  assign char_accept = char_valid && !char_stall;
  assign result_load = s1_adv && cls.is_term;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (char_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (char_accept) begin
      s1_char <= character;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      address_valid <= parse_res.ok;
      address       <= parse_res.ok ? parse_res.addr : '0;
    end
  end

endmodule
